// File: rtl/core/hrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_pkg: shared types and codes for the hierarchical range cache
// Result codes, opcodes and the sequencer state type.
// ----------------------------------------------------------------------------
package hrc_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    RC_INSERTED = 3'd0,
    RC_PRESENT  = 3'd1,
    RC_FULL     = 3'd2,
    RC_EXACT    = 3'd3,
    RC_ANCESTOR = 3'd4,
    RC_NONE     = 3'd5
  } result_code_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FETCH,
    ST_DONE
  } seq_state_e;

endpackage

// File: rtl/core/hrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_if: valid/ready channel
// Carries one item with a parametrized payload type.
// ----------------------------------------------------------------------------
interface hrc_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/hrc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrc_div #(
  parameter int W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [W:0] trial;

  // One shift-subtract step
  always_comb begin
    trial  = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/core/hrc_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_mem: entry store
// Single-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module hrc_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 96,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// File: rtl/core/hierarchical_range_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_range_cache: range table keyed by piece index and count
// Insert widens ancestors and appends unless present or full; search finds exact or best ancestor.
// ----------------------------------------------------------------------------
// Walk: each stored entry is read and checked; an entry whose nonzero count
// is below the request's also needs the divide before its update; then the
// result is formed, for a search with a hit after fetching the best entry.
// Throughput: one item at a time; the walk over the entry memory with the
// shared iterative divider sets the rate. A new item is taken while a result
// waits; its last step holds until that result has left.
// Reset: the fill count clears; the entry memory is not cleared (only filled
// entries are ever used).
module hierarchical_range_cache #(
  parameter int TABLE_DEPTH = 64,
  parameter int PIECE_BITS  = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  hrc_if.sink   req,
  hrc_if.source rsp
);
  import hrc_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = 2 * PIECE_BITS + 2 * VALUE_BITS;
  localparam int PB = PIECE_BITS;
  localparam int VB = VALUE_BITS;

  // request fields
  logic          op_q;
  logic [PB-1:0] p_q, n_q;
  logic signed [VB-1:0] lo_q, hi_q;

  seq_state_e state_q, state_d;
  logic [UW-1:0] used_q, used_d, idx_q, idx_d;
  logic [AW-1:0] best_q, best_d;
  logic [PB-1:0] bestcnt_q, bestcnt_d;
  logic have_q, have_d;
  result_code_e code_q, code_d;
  logic signed [VB-1:0] flo_q, flo_d, fhi_q, fhi_d;
  logic out_v_q, out_v_d;
  logic out_free;

  // memory port
  logic          we;
  logic [AW-1:0] addr;
  logic [DW-1:0] wdata, rdata;
  logic [PB-1:0] e_piece, e_count;
  logic signed [VB-1:0] e_low, e_high;

  assign e_piece = rdata[DW-1 -: PB];
  assign e_count = rdata[DW-PB-1 -: PB];
  assign e_low   = rdata[2*VB-1 -: VB];
  assign e_high  = rdata[VB-1:0];

  hrc_mem #(.DEPTH(TABLE_DEPTH), .DW(DW), .AW(AW)) u_mem (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // shared divider: request count n / entry count
  logic div_start, div_done;
  logic [PB-1:0] quo, step_q;

  hrc_div #(.W(PB)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(n_q), .den_i(e_count),
    .done_o(div_done), .quo_o(quo)
  );

  // entry word held during the divide
  logic [DW-1:0] ent_q;
  logic [PB-1:0] h_piece, h_count;
  logic signed [VB-1:0] h_low, h_high;
  assign h_piece = ent_q[DW-1 -: PB];
  assign h_count = ent_q[DW-PB-1 -: PB];
  assign h_low   = ent_q[2*VB-1 -: VB];
  assign h_high  = ent_q[VB-1:0];

  // p / step == piece  <=>  piece*step <= p < piece*step + step, step >= 1
  logic [2*PB-1:0] span_lo;
  logic [2*PB:0]   span_lo_x, span_hi_x, p_x;
  logic            anc_hit;
  assign span_lo   = {{PB{1'b0}}, h_piece} * {{PB{1'b0}}, step_q};
  assign span_lo_x = {1'b0, span_lo};
  assign span_hi_x = span_lo_x + {{(PB+1){1'b0}}, step_q};
  assign p_x       = {{(PB+1){1'b0}}, p_q};
  assign anc_hit   = (p_x >= span_lo_x) && (p_x < span_hi_x);

  logic exact_hit;
  assign exact_hit = (e_piece == p_q) && (e_count == n_q);

  // result register free this cycle
  assign out_free = !out_v_q || rsp.ready;

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    idx_d     = idx_q;
    best_d    = best_q;
    bestcnt_d = bestcnt_q;
    have_d    = have_q;
    code_d    = code_q;
    flo_d     = flo_q;
    fhi_d     = fhi_q;
    out_v_d   = out_v_q;
    we        = 1'b0;
    addr      = idx_q[AW-1:0];
    wdata     = ent_q;
    div_start = 1'b0;
    req.ready = 1'b0;

    if (out_v_q && rsp.ready) out_v_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          idx_d  = '0;
          have_d = 1'b0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (idx_q >= used_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // read data of entry idx is valid now
        if (exact_hit) begin
          if (out_free) begin
            if (op_q == OP_INSERT) begin
              code_d = RC_PRESENT;
              flo_d = '0;
              fhi_d = '0;
            end else begin
              code_d = RC_EXACT;
              flo_d = e_low;
              fhi_d = e_high;
            end
            out_v_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (e_count != '0 && e_count < n_q) begin
          div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          idx_d = idx_q + UW'(1);
          state_d = ST_READ;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (anc_hit) begin
          if (op_q == OP_INSERT) begin
            we = 1'b1;
            wdata = {h_piece, h_count,
                     (h_low > lo_q) ? lo_q : h_low,
                     (h_high < hi_q) ? hi_q : h_high};
          end else if (!have_q || h_count > bestcnt_q) begin
            have_d    = 1'b1;
            best_d    = idx_q[AW-1:0];
            bestcnt_d = h_count;
          end
        end
        idx_d = idx_q + UW'(1);
        state_d = ST_READ;
      end
      ST_DONE: begin
        if (op_q == OP_INSERT) begin
          if (out_free) begin
            flo_d = '0;
            fhi_d = '0;
            if (used_q >= UW'(TABLE_DEPTH)) begin
              code_d = RC_FULL;
            end else begin
              we = 1'b1;
              addr = used_q[AW-1:0];
              wdata = {p_q, n_q, lo_q, hi_q};
              used_d = used_q + UW'(1);
              code_d = RC_INSERTED;
            end
            out_v_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (have_q) begin
          addr = best_q;
          state_d = ST_FETCH;
        end else if (out_free) begin
          flo_d = '0;
          fhi_d = '0;
          code_d = RC_NONE;
          out_v_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FETCH: begin
        // keep the best entry on the read port while the result waits
        addr = best_q;
        if (out_free) begin
          code_d = RC_ANCESTOR;
          flo_d = e_low;
          fhi_d = e_high;
          out_v_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      out_v_q <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      out_v_q <= out_v_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    best_q    <= best_d;
    bestcnt_q <= bestcnt_d;
    code_q    <= code_d;
    flo_q     <= flo_d;
    fhi_q     <= fhi_d;
    if (state_q == ST_CHECK) ent_q <= rdata;
    if (div_done) step_q <= quo;
    if (req.valid && req.ready) begin
      op_q <= req.data.opcode;
      p_q  <= req.data.piece_index;
      n_q  <= req.data.piece_count;
      lo_q <= req.data.range_low;
      hi_q <= req.data.range_high;
    end
  end

  assign rsp.valid            = out_v_q;
  assign rsp.data.result_code = code_q;
  assign rsp.data.found_low   = flo_q;
  assign rsp.data.found_high  = fhi_q;

  // fill count never exceeds the table
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(TABLE_DEPTH)) else $error("fill count overflow");
  // a waiting result stays put until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !rsp.ready |=> out_v_q && $stable(code_q) && $stable(flo_q) &&
    $stable(fhi_q)) else $error("result changed while waiting");
  // fill count moves by at most one
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != $past(used_q) |-> used_q == $past(used_q) + UW'(1))
    else $error("fill count jump");
endmodule
